// ===== design/scle_pkg.sv =====
// Package: widths, scan codes, action codes and key tables of the scan-code line editor.
`timescale 1ns / 1ps
package scle_pkg;

  localparam int LINE_LEN   = 128;
  localparam int TAB_SPACES = 4;
  localparam int KEY_CNT    = 54;

  localparam int SCAN_W = 8;
  localparam int CHAR_W = 7;
  localparam int CON_W  = 2;
  localparam int POS_W  = $clog2(LINE_LEN);
  localparam int CNT_W  = $clog2(TAB_SPACES + 1);
  localparam int IDX_W  = $clog2(KEY_CNT);

  typedef enum logic [1:0] {
    ACT_PRINT   = 2'd0,
    ACT_ERASE   = 2'd1,
    ACT_CLEAR   = 2'd2,
    ACT_CONSOLE = 2'd3
  } action_t;

  // Set-1 codes of interest
  localparam logic [SCAN_W-1:0] SC_BKSP     = 8'h0E;
  localparam logic [SCAN_W-1:0] SC_TAB      = 8'h0F;
  localparam logic [SCAN_W-1:0] SC_ENTER    = 8'h1C;
  localparam logic [SCAN_W-1:0] SC_CTRL     = 8'h1D;
  localparam logic [SCAN_W-1:0] SC_CTRL_BRK = 8'h9D;
  localparam logic [SCAN_W-1:0] SC_L        = 8'h26;
  localparam logic [SCAN_W-1:0] SC_LSHIFT   = 8'h2A;
  localparam logic [SCAN_W-1:0] SC_LSH_BRK  = 8'hAA;
  localparam logic [SCAN_W-1:0] SC_RSHIFT   = 8'h36;
  localparam logic [SCAN_W-1:0] SC_RSH_BRK  = 8'hB6;
  localparam logic [SCAN_W-1:0] SC_ALT      = 8'h38;
  localparam logic [SCAN_W-1:0] SC_ALT_BRK  = 8'hB8;
  localparam logic [SCAN_W-1:0] SC_SPACE    = 8'h39;
  localparam logic [SCAN_W-1:0] SC_CAPS     = 8'h3A;
  localparam logic [SCAN_W-1:0] SC_F1       = 8'h3B;
  localparam logic [SCAN_W-1:0] SC_F3       = 8'h3D;

  localparam logic [CHAR_W-1:0] CH_NL    = 7'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;

  typedef logic [0:KEY_CNT-1][7:0] key_tbl_t;

  localparam key_tbl_t TBL_PLAIN =
    "..1234567890-=..qwertyuiop[]..asdfghjkl;'`.\\zxcvbnm,./";
  localparam key_tbl_t TBL_CAPS =
    "..1234567890-=..QWERTYUIOP[]..ASDFGHJKL;'`.\\ZXCVBNM,./";
  localparam key_tbl_t TBL_SHIFT =
    "..!@#$%^&*()_+..QWERTYUIOP{}..ASDFGHJKL:\"~.|ZXCVBNM<>?";
  localparam key_tbl_t TBL_CAPS_SHIFT =
    "..!@#$%^&*()_+..qwertyuiop{}..asdfghjkl:\"~.|zxcvbnm<>?";

  typedef struct packed {
    action_t           action;
    logic [CHAR_W-1:0] char_out;
    logic [CON_W-1:0]  console_num;
    logic              line_ready;
  } run_t;

endpackage

// ===== design/scle_ifs.sv =====
// Interfaces: scan-code input channel and console action result channel.
`timescale 1ns / 1ps
interface scle_in_if;
  import scle_pkg::*;
  logic              valid;
  logic              ready;
  logic [SCAN_W-1:0] scan_code;
  modport source (output valid, output scan_code, input ready);
  modport sink   (input valid, input scan_code, output ready);
endinterface

interface scle_out_if;
  import scle_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [CHAR_W-1:0] char_out;
  logic [CON_W-1:0]  console_num;
  logic              line_ready;
  logic              last_of_run;
  modport source (output valid, output action, output char_out, output console_num,
                  output line_ready, output last_of_run, input ready);
  modport sink   (input valid, input action, input char_out, input console_num,
                  input line_ready, input last_of_run, output ready);
endinterface

// ===== design/scancode_to_ascii_line_editor_core.sv =====
// Top level: set-1 scan-code decoder and line editor with a registered result run.
`timescale 1ns / 1ps
// Usage
// - in_ch carries one raw set-1 scan code per transfer (valid/ready).
// - out_ch carries console actions: print, erase, clear screen, switch
//   console. One scan code gives zero to four results; the last one has
//   last_of_run set.
// - Decoding, modifier update and line position update all happen in the
//   cycle of the input transfer; the results sit in a run register and are
//   shown from the next cycle on, one per cycle while out_ch is ready.
// - A tab gives up to four results, as the run counter replays the space.
//   A new code is taken in the same cycle as the last result of the
//   previous run leaves.
// - A stalled out_ch holds the current result; in_ch stays not ready until
//   the run's last result is transferred.
// - Reset (rst_n low, synchronous) clears caps lock, shift, ctrl, alt, the
//   line position and any pending run.
// - The line holds LINE_LEN-1 characters; further characters are dropped,
//   newline is always printed and returns the position to zero.
module scancode_to_ascii_line_editor_core (
  input  logic        clk,
  input  logic        rst_n,
  scle_in_if.sink     in_ch,
  scle_out_if.source  out_ch
);
  import scle_pkg::*;

  localparam logic [POS_W-1:0] POS_FULL = POS_W'(LINE_LEN - 1);
  localparam logic [POS_W-1:0] TAB_MAX  = POS_W'(TAB_SPACES);

  // modifier and line state
  logic             caps_r, caps_nxt;
  logic             shift_r, shift_nxt;
  logic             ctrl_r, ctrl_nxt;
  logic             alt_r, alt_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;

  // result run: fields shared by every result, count of results still to go
  run_t             run_r, run_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic              in_xfer;
  logic              out_xfer;
  logic [SCAN_W-1:0] c;
  logic              printable;
  logic [IDX_W-1:0]  idx;
  logic [7:0]        key_byte;
  logic [POS_W-1:0]  room;
  logic [CNT_W-1:0]  tab_n;
  logic              line_full;

  assign out_xfer    = out_ch.valid && out_ch.ready;
  // free, or the run's last result leaves now
  assign in_ch.ready = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_ch.ready);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign c           = in_ch.scan_code;

  assign out_ch.valid       = (cnt_r != '0);
  assign out_ch.action      = run_r.action;
  assign out_ch.char_out    = run_r.char_out;
  assign out_ch.console_num = run_r.console_num;
  assign out_ch.line_ready  = run_r.line_ready;
  assign out_ch.last_of_run = (cnt_r == CNT_W'(1));

  always_comb begin
    printable = c inside {[8'h02:8'h0D], [8'h10:8'h1B], [8'h1E:8'h29], [8'h2B:8'h35]};
  end

  // index stays in table range; it only matters for printable codes
  assign idx = printable ? c[IDX_W-1:0] : '0;

  always_comb begin
    case ({caps_nxt, shift_nxt})
      2'b00:   key_byte = TBL_PLAIN[idx];
      2'b01:   key_byte = TBL_SHIFT[idx];
      2'b10:   key_byte = TBL_CAPS[idx];
      default: key_byte = TBL_CAPS_SHIFT[idx];
    endcase
  end

  assign line_full = (pos_r >= POS_FULL);
  assign room      = POS_FULL - pos_r;
  assign tab_n     = (room >= TAB_MAX) ? CNT_W'(TAB_SPACES) : room[CNT_W-1:0];

  // modifiers update before the key itself is decoded
  always_comb begin
    caps_nxt  = caps_r ^ (c == SC_CAPS);
    ctrl_nxt  = ctrl_r;
    alt_nxt   = alt_r;
    shift_nxt = shift_r;
    if (c == SC_CTRL) begin
      ctrl_nxt = 1'b1;
    end else if (c == SC_CTRL_BRK) begin
      ctrl_nxt = 1'b0;
    end
    if (c == SC_ALT) begin
      alt_nxt = 1'b1;
    end else if (c == SC_ALT_BRK) begin
      alt_nxt = 1'b0;
    end
    if (c == SC_LSHIFT || c == SC_RSHIFT) begin
      shift_nxt = 1'b1;
    end else if (c == SC_LSH_BRK || c == SC_RSH_BRK) begin
      shift_nxt = 1'b0;
    end
  end

  // decode: ctrl wins over alt, both over printing
  always_comb begin
    run_nxt             = run_r;
    cnt_nxt             = cnt_r;
    pos_nxt             = pos_r;
    if (out_xfer) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    if (in_xfer) begin
      run_nxt.action      = ACT_PRINT;
      run_nxt.char_out    = '0;
      run_nxt.console_num = '0;
      run_nxt.line_ready  = 1'b0;
      cnt_nxt             = '0;
      if (ctrl_nxt && c == SC_L) begin
        run_nxt.action = ACT_CLEAR;
        cnt_nxt        = CNT_W'(1);
      end else if (alt_nxt && c >= SC_F1 && c <= SC_F3) begin
        run_nxt.action      = ACT_CONSOLE;
        run_nxt.console_num = CON_W'(c - SC_CAPS);
        cnt_nxt             = CNT_W'(1);
      end else if (printable) begin
        run_nxt.char_out = key_byte[CHAR_W-1:0];
        if (!line_full) begin
          cnt_nxt = CNT_W'(1);
          pos_nxt = pos_r + POS_W'(1);
        end
      end else if (c == SC_ENTER) begin
        run_nxt.char_out   = CH_NL;
        run_nxt.line_ready = 1'b1;
        cnt_nxt            = CNT_W'(1);
        pos_nxt            = '0;
      end else if (c == SC_SPACE) begin
        run_nxt.char_out = CH_SPACE;
        if (!line_full) begin
          cnt_nxt = CNT_W'(1);
          pos_nxt = pos_r + POS_W'(1);
        end
      end else if (c == SC_TAB) begin
        // spaces up to the tab width, stopping at the end of the line
        run_nxt.char_out = CH_SPACE;
        if (!line_full) begin
          cnt_nxt = tab_n;
          pos_nxt = pos_r + POS_W'(tab_n);
        end
      end else if (c == SC_BKSP) begin
        run_nxt.action = ACT_ERASE;
        if (pos_r != '0) begin
          cnt_nxt = CNT_W'(1);
          pos_nxt = pos_r - POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      caps_r  <= 1'b0;
      shift_r <= 1'b0;
      ctrl_r  <= 1'b0;
      alt_r   <= 1'b0;
      pos_r   <= '0;
      cnt_r   <= '0;
    end else begin
      if (in_xfer) begin
        caps_r  <= caps_nxt;
        shift_r <= shift_nxt;
        ctrl_r  <= ctrl_nxt;
        alt_r   <= alt_nxt;
      end
      pos_r <= pos_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_r <= run_nxt;
  end

endmodule
